### design/assert_macros.svh
// Assertion macros for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/cral_pkg.sv
// ----------------------------------------------------------------------------
// cral_pkg
// Shared types and constants for the color ramp age lookup.
// ----------------------------------------------------------------------------
package cral_pkg;
  localparam int RAMP_DEPTH = 256;
  localparam int FRAC_BITS  = 8;
  localparam int AW         = $clog2(RAMP_DEPTH);
  localparam int NUM_W      = 32 + 8 + FRAC_BITS;
  localparam int QD         = 4;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_INIT = 2'd1;
  localparam logic [1:0] CMD_EVAL = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [AW-1:0] waddr;
    logic        wen;
    logic [31:0] rgba;
    logic [31:0] ttl;
    logic [31:0] total;
  } job_t;
endpackage

### design/cral_if.sv
// ----------------------------------------------------------------------------
// cral_in_if / cral_out_if / cral_cfg_if
// Valid/ready channels of the color ramp lookup.
// ----------------------------------------------------------------------------
interface cral_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  entry_index;
  logic [31:0] entry_rgba;
  logic [31:0] time_to_live;
  logic [31:0] total_life;
  modport source (output valid, cmd, entry_index, entry_rgba, time_to_live, total_life,
                  input ready);
  modport sink (input valid, cmd, entry_index, entry_rgba, time_to_live, total_life,
                output ready);
endinterface

interface cral_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  logic [15:0] alpha_out;
  modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

interface cral_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### design/cral_ram.sv
// ----------------------------------------------------------------------------
// cral_ram
// Generic single-port-write, one-read RAM with registered read.
// ----------------------------------------------------------------------------
module cral_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/cral_front.sv
// ----------------------------------------------------------------------------
// cral_front
// Accepts items, drops unused codes, queues jobs for the back end.
// ----------------------------------------------------------------------------
module cral_front import cral_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  cral_in_if.sink in_ch,
  output logic  job_valid,
  input  logic  job_pop,
  output job_t  job
);
  localparam int PW = $clog2(QD);

  job_t          q_r [QD];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;
  logic          push;
  job_t          nj;

  assign in_ch.ready = (cnt_r != (PW+1)'(QD));
  assign push = in_ch.valid && in_ch.ready &&
                (in_ch.cmd == CMD_LOAD || in_ch.cmd == CMD_INIT || in_ch.cmd == CMD_EVAL);
  assign job_valid = (cnt_r != '0);
  assign job = q_r[rp_r];

  always_comb begin
    nj.cmd   = in_ch.cmd;
    nj.waddr = in_ch.entry_index[AW-1:0];
    nj.wen   = (32'(in_ch.entry_index) < 32'(RAMP_DEPTH));
    nj.rgba  = in_ch.entry_rgba;
    nj.ttl   = in_ch.time_to_live;
    nj.total = in_ch.total_life;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (job_pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(job_pop);
    end
    if (push) begin
      q_r[wp_r] <= nj;
    end
  end
endmodule

### design/cral_back.sv
// ----------------------------------------------------------------------------
// cral_back
// Executes jobs: ramp writes, init reads, age division and channel blend.
// ----------------------------------------------------------------------------
module cral_back import cral_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] last_cfg,
  input  logic       job_valid,
  output logic       job_pop,
  input  job_t       job,
  cral_out_if.source out_ch
);
  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DIV, S_RD0, S_RD1, S_RD2, S_BLEND, S_OUT
  } state_t;

  localparam int CW = $clog2(NUM_W + 1);

  state_t            state_r;
  logic [NUM_W-1:0]  quo_r;
  logic [32:0]       rem_r;
  logic [31:0]       d_r, den_r;
  logic [AW-1:0]     last_r, idx_r, raddr_r;
  logic [CW-1:0]     cnt_r;
  logic [31:0]       lo_r, rdata;
  logic [FRAC_BITS-1:0] f_r;
  logic              direct_r;
  logic [15:0]       ch_r [4];
  logic [32:0]       rem_sh;
  logic [AW-1:0]     lsat;
  logic              we;

  assign lsat = (32'(last_cfg) > 32'(RAMP_DEPTH - 1)) ? AW'(RAMP_DEPTH - 1)
                                                       : AW'(last_cfg);
  assign we = (state_r == S_IDLE) && job_valid && job.cmd == CMD_LOAD && job.wen;
  assign job_pop = (state_r == S_IDLE) && job_valid;
  assign rem_sh = {rem_r[31:0], quo_r[NUM_W-1]};

  cral_ram #(.WIDTH(32), .DEPTH(RAMP_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(job.waddr), .wdata(job.rgba),
    .raddr(raddr_r), .rdata(rdata)
  );

  assign out_ch.valid     = (state_r == S_OUT);
  assign out_ch.red_out   = ch_r[0];
  assign out_ch.green_out = ch_r[1];
  assign out_ch.blue_out  = ch_r[2];
  assign out_ch.alpha_out = ch_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (job_valid && job.cmd == CMD_INIT) begin
            raddr_r  <= '0;
            direct_r <= 1'b1;
            state_r  <= S_RD1;
          end else if (job_valid && job.cmd == CMD_EVAL) begin
            last_r <= lsat;
            den_r  <= job.total;
            d_r    <= (job.total != '0 && job.ttl <= job.total) ? job.total - job.ttl : '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          quo_r <= NUM_W'({40'(d_r) * 40'(last_r), {FRAC_BITS{1'b0}}});
          rem_r <= '0;
          cnt_r <= CW'(NUM_W);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (den_r == '0) begin
            quo_r   <= '0;
            state_r <= S_RD0;
          end else begin
            if (rem_sh >= {1'b0, den_r}) begin
              rem_r <= rem_sh - {1'b0, den_r};
              quo_r <= {quo_r[NUM_W-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[NUM_W-2:0], 1'b0};
            end
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == CW'(1)) begin
              state_r <= S_RD0;
            end
          end
        end
        S_RD0: begin
          f_r <= quo_r[FRAC_BITS-1:0];
          if (quo_r[NUM_W-1:FRAC_BITS] >= (NUM_W-FRAC_BITS)'(last_r)) begin
            raddr_r  <= last_r;
            direct_r <= 1'b1;
          end else begin
            idx_r    <= quo_r[FRAC_BITS+AW-1:FRAC_BITS];
            raddr_r  <= quo_r[FRAC_BITS+AW-1:FRAC_BITS];
            direct_r <= 1'b0;
          end
          state_r <= S_RD1;
        end
        S_RD1: begin
          raddr_r <= idx_r + 1'b1;
          state_r <= S_RD2;
        end
        S_RD2: begin
          lo_r <= rdata;
          if (direct_r) begin
            for (int c = 0; c < 4; c++) begin
              ch_r[c] <= {rdata[8*c +: 8], 8'd0};
            end
            state_r <= S_OUT;
          end else begin
            state_r <= S_BLEND;
          end
        end
        S_BLEND: begin
          for (int c = 0; c < 4; c++) begin
            ch_r[c] <= 16'(((({1'b0, ~f_r} + 1'b1) * (FRAC_BITS + 17)'(lo_r[8*c +: 8]) +
                       (FRAC_BITS + 17)'(f_r) * (FRAC_BITS + 17)'(rdata[8*c +: 8])) << 8)
                       >> FRAC_BITS);
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

### design/color_ramp_age_lookup.sv
// ----------------------------------------------------------------------------
// color_ramp_age_lookup
// Particle color by age from an RGBA ramp.
// ----------------------------------------------------------------------------
// A load word is written to the ramp RAM once it leaves the job queue. An evaluate
// word takes its age ratio from a restoring divider that retires one of 48
// quotient bits per cycle, then two ramp RAM reads and a blend, which is skipped
// when the ramp position reaches the last entry. A four-deep queue lets the input
// side keep taking words while one is in work.
module color_ramp_age_lookup import cral_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  cral_in_if.sink    in_ch,
  cral_out_if.source out_ch,
  cral_cfg_if.sink   cfg_ch
);
  logic [7:0] last_r;
  logic       job_valid, job_pop;
  job_t       job;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
    end else if (cfg_ch.valid) begin
      last_r <= cfg_ch.data;
    end
  end

  cral_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .job_valid(job_valid), .job_pop(job_pop), .job(job)
  );

  cral_back u_back (
    .clk(clk), .rst_n(rst_n), .last_cfg(last_r),
    .job_valid(job_valid), .job_pop(job_pop), .job(job), .out_ch(out_ch)
  );
endmodule

### design/cral_checker.sv
// ----------------------------------------------------------------------------
// cral_checker
// Port-level checks for the color ramp lookup.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cral_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] red_out,
  input logic [15:0] alpha_out,
  input logic        in_valid,
  input logic        in_ready
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(red_out))
  `ASSERT_IMPL(a_red_range, clk, rst_n, out_valid, red_out[7:0] == 8'd0 || red_out <= 16'd65280)
  `ASSERT_IMPL(a_alpha_range, clk, rst_n, out_valid, alpha_out <= 16'd65280)
  `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)
endmodule

bind color_ramp_age_lookup cral_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .red_out(out_ch.red_out), .alpha_out(out_ch.alpha_out),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready)
);

### bench/tb_color_ramp_age_lookup.sv
// ----------------------------------------------------------------------------
// tb_color_ramp_age_lookup
// Self-checking bench for the color ramp age lookup: ramp loads, init and
// evaluate words against an internal predictor, random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_color_ramp_age_lookup;
  timeunit 1ns;
  timeprecision 1ps;
  import cral_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  eidx;
    logic [31:0] rgba;
    logic [31:0] ttl;
    logic [31:0] total;
  } word_t;

  typedef struct packed {
    logic [15:0] r, g, b, a;
  } color_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  cral_in_if  in_ch();
  cral_out_if out_ch();
  cral_cfg_if cfg_ch();

  color_ramp_age_lookup uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                             .cfg_ch(cfg_ch));

  word_t  pending[$];
  color_t colors_due[$];
  logic [31:0] ramp_model[RAMP_DEPTH];
  logic [7:0]  last_model;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int errors = 0;
  logic cfg_pend = 1'b0;
  logic [7:0] cfg_val;

  function automatic color_t entry_color(logic [31:0] rgba);
    color_t c;
    c.r = {rgba[7:0], 8'd0};
    c.g = {rgba[15:8], 8'd0};
    c.b = {rgba[23:16], 8'd0};
    c.a = {rgba[31:24], 8'd0};
    return c;
  endfunction

  function automatic logic [15:0] blend_ch(logic [7:0] lo, logic [7:0] hi, logic [8:0] f);
    logic [31:0] sum;
    sum = lo * (32'd256 - f) + hi * f;
    return sum[15:0];
  endfunction

  function automatic color_t age_color(logic [31:0] ttl, logic [31:0] total);
    logic [63:0] d, pos, idx;
    logic [8:0]  f;
    logic [31:0] lo, hi;
    color_t c;
    d = 0;
    pos = 0;
    if (total != 0 && ttl <= total) d = total - ttl;
    if (total != 0) pos = ((d * last_model) << FRAC_BITS) / total;
    idx = pos >> FRAC_BITS;
    f = {1'b0, pos[7:0]};
    if (idx >= last_model) return entry_color(ramp_model[last_model]);
    lo = ramp_model[idx];
    hi = ramp_model[idx + 1];
    c.r = blend_ch(lo[7:0], hi[7:0], f);
    c.g = blend_ch(lo[15:8], hi[15:8], f);
    c.b = blend_ch(lo[23:16], hi[23:16], f);
    c.a = blend_ch(lo[31:24], hi[31:24], f);
    return c;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        word_t w;
        w = pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= w.cmd;
        in_ch.entry_index <= w.eidx;
        in_ch.entry_rgba <= w.rgba;
        in_ch.time_to_live <= w.ttl;
        in_ch.total_life <= w.total;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // accepted input -> prediction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      case (in_ch.cmd)
        CMD_LOAD: ramp_model[in_ch.entry_index] = in_ch.entry_rgba;
        CMD_INIT: colors_due.push_back(entry_color(ramp_model[0]));
        CMD_EVAL: colors_due.push_back(age_color(in_ch.time_to_live, in_ch.total_life));
        default: ;
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        color_t got, want;
        got = {out_ch.red_out, out_ch.green_out, out_ch.blue_out, out_ch.alpha_out};
        if (colors_due.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          want = colors_due.pop_front();
          if (got.r !== want.r) begin
            $display("%0t: red exp %h got %h", $time, want.r, got.r); errors++;
          end
          if (got.g !== want.g) begin
            $display("%0t: green exp %h got %h", $time, want.g, got.g); errors++;
          end
          if (got.b !== want.b) begin
            $display("%0t: blue exp %h got %h", $time, want.b, got.b); errors++;
          end
          if (got.a !== want.a) begin
            $display("%0t: alpha exp %h got %h", $time, want.a, got.a); errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // config driver
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      cfg_ch.valid <= 1'b0;
      last_model = cfg_ch.data;
    end else if (cfg_pend && !cfg_ch.valid) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= cfg_val;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_LOAD;
    in_ch.entry_index = '0;
    in_ch.entry_rgba = '0;
    in_ch.time_to_live = '0;
    in_ch.total_life = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    last_model = '0;
  end

  task automatic push(logic [1:0] cmd, logic [7:0] eidx, logic [31:0] rgba,
                      logic [31:0] ttl, logic [31:0] total);
    pending.push_back({cmd, eidx, rgba, ttl, total});
  endtask

  task automatic drain();
    wait (pending.size() == 0);
    @(posedge clk);
    while (in_ch.valid || colors_due.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_last(logic [7:0] v);
    drain();
    cfg_val = v;
    cfg_pend = 1'b1;
    @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge clk);
    cfg_pend = 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_life();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(4096);
      2: return 32'hFFFF_FFFF - $urandom_range(3);
      default: return {16'd0, 16'($urandom)};
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [31:0] t, tt;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1: push(CMD_LOAD, 8'($urandom), $urandom, $urandom, $urandom);
        2: push(CMD_INIT, 8'($urandom), $urandom, $urandom, $urandom);
        3: push(CMD_NONE, 8'($urandom), $urandom, $urandom, $urandom);
        default: begin
          t = rand_life();
          tt = ($urandom_range(4) == 0) ? rand_life() : (t == 0 ? 0 : $urandom_range(t));
          push(CMD_EVAL, 8'($urandom), $urandom, tt, t);
        end
      endcase
    end
  endtask

  initial begin
    logic [7:0] lasts[6];
    lasts = '{8'd0, 8'd255, 8'd1, 8'd17, 8'd200, 8'd3};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // whole ramp written first so no read sees an unwritten entry
    for (int i = 0; i < RAMP_DEPTH; i++) push(CMD_LOAD, i[7:0], $urandom, 0, 0);
    push(CMD_LOAD, 8'd0, 32'h0000_0000, 0, 0);
    push(CMD_LOAD, 8'd1, 32'hFFFF_FFFF, 0, 0);
    push(CMD_LOAD, 8'd255, 32'hFF00_FF00, 0, 0);
    push(CMD_INIT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push(CMD_EVAL, 8'd0, 0, 32'd5, 32'd0);
    push(CMD_EVAL, 8'd0, 0, 32'hFFFF_FFFF, 32'd1);
    push(CMD_EVAL, 8'd0, 0, 32'd0, 32'hFFFF_FFFF);
    push(CMD_EVAL, 8'd0, 0, 32'h0001_0000, 32'h0002_0000);
    push(CMD_NONE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_last(8'd255);
    push(CMD_EVAL, 8'd0, 0, 32'd0, 32'hFFFF_FFFF);
    push(CMD_EVAL, 8'd0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    push(CMD_EVAL, 8'd0, 0, 32'd1, 32'd512);
    push(CMD_EVAL, 8'd0, 0, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    for (int p = 0; p < 6; p++) begin
      set_last(lasts[p]);
      in_idle_pct = (p < 2) ? 19 : (p < 4) ? 83 : 0;
      out_idle_pct = (p < 2) ? 83 : (p < 4) ? 19 : 0;
      random_phase(160);
    end
    drain();
    if (errors == 0 && colors_due.size() == 0) begin
      $display("** color_ramp_age_lookup: PASSED **");
    end else begin
      $display("** color_ramp_age_lookup: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** color_ramp_age_lookup: FAILED **");
    $finish;
  end
endmodule
